>>> hw/rtl/apc_pkg.sv
// shared types and constants for the alpha premultiply pixel converter
`default_nettype none
package apc_pkg;

	localparam int CH_W   = 8;
	localparam int LANES  = 3;
	localparam int PROD_W = 2 * CH_W;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_LAYOUT         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_TARGET        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PREMULTIPLIED = 2'd2;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [CH_W-1:0] CH_MAX       = 8'hFF;

	// per-lane operation
	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_MUL  = 2'd1,
		MODE_DIV  = 2'd2
	} apc_mode_t;

	// stage load strobes shared by lanes and side pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} apc_ld_t;

	// per-item data that travels beside the lanes
	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic            last;
		logic            target;
	} apc_side_t;

endpackage
`default_nettype wire

>>> hw/rtl/alpha_premultiply_pixel_converter.sv
// top level: config registers, lane pipeline control and output stage
`default_nettype none
// Converts one 32-bit pixel per item between ARGB and ABGR word layouts,
// premultiplying colour by alpha for target 0 from an unpremultiplied source
// or dividing it back out for target 1 from a premultiplied source when
// alpha is not opaque. Three identical colour lanes run side by side; each
// takes a product in stage 1, does half of an 8-step restoring divide in
// stage 2 and the other half in stage 3, and the merge stage packs the word
// into the output register. An item can be accepted every clock while
// in_stall is low; its result passes through stage 1, the two divider stages
// in each lane and the output register. Stages hold their contents and
// empty stages keep filling while the output is stalled, so in_stall only
// rises once the whole pipeline is full. Configuration is taken through
// cfg_we/cfg_index/cfg_data; only bit 0 is used and indexes beyond the three registers are dropped.
module alpha_premultiply_pixel_converter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [apc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic                              cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [31:0]                       pixel_word,
	input  wire logic                              last_pixel,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [31:0]                            out_word,
	output logic                                   out_last
);

	localparam int W = apc_pkg::CH_W;

	// configuration registers
	logic layout_q, target_q, prem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b0;
			target_q <= 1'b0;
			prem_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				apc_pkg::CFG_INPUT_LAYOUT:         layout_q <= cfg_data;
				apc_pkg::CFG_OUTPUT_TARGET:        target_q <= cfg_data;
				apc_pkg::CFG_SOURCE_PREMULTIPLIED: prem_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack the source pixel
	logic [W-1:0] a_in, r_in, g_in, b_in;

	always_comb begin
		a_in = pixel_word[31:24];
		g_in = pixel_word[15:8];
		if (layout_q) begin
			r_in = pixel_word[7:0];
			b_in = pixel_word[23:16];
		end else begin
			r_in = pixel_word[23:16];
			b_in = pixel_word[7:0];
		end
	end

	// choose the lane operation once per item
	apc_pkg::apc_mode_t mode_in;

	always_comb begin
		if (!target_q && !prem_q) begin
			mode_in = apc_pkg::MODE_MUL;
		end else if (target_q && prem_q && a_in != apc_pkg::ALPHA_OPAQUE) begin
			mode_in = apc_pkg::MODE_DIV;
		end else begin
			mode_in = apc_pkg::MODE_PASS;
		end
	end

	// pipeline occupancy and load strobes; a stage loads when its
	// predecessor holds an item and it is empty or being drained
	logic v_s1, v_s2, v_s3;
	apc_pkg::apc_ld_t ld;
	logic adv1, adv2, adv3;

	always_comb begin
		ld.s4 = v_s3 && (!out_valid || !out_stall);
		adv3  = !v_s3 || ld.s4;
		ld.s3 = v_s2 && adv3;
		adv2  = !v_s2 || ld.s3;
		ld.s2 = v_s1 && adv2;
		adv1  = !v_s1 || ld.s2;
		ld.s1 = in_valid && adv1;
	end

	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= ld.s1 || (v_s1 && !ld.s2);
			v_s2      <= ld.s2 || (v_s2 && !ld.s3);
			v_s3      <= ld.s3 || (v_s3 && !ld.s4);
			out_valid <= ld.s4 || (out_valid && out_stall);
		end
	end

	// side data: alpha, last flag and target ride beside the lanes
	apc_pkg::apc_side_t side_s1, side_s2, side_s3;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			side_s1 <= '{alpha: a_in, last: last_pixel, target: target_q};
		end
		if (ld.s2) begin
			side_s2 <= side_s1;
		end
		if (ld.s3) begin
			side_s3 <= side_s2;
		end
	end

	// colour lanes: red, green, blue
	logic [W-1:0] r_res, g_res, b_res;

	apc_lane u_lane_r (
		.clk   (clk),
		.ld    (ld),
		.mode  (mode_in),
		.chan  (r_in),
		.alpha (a_in),
		.res   (r_res)
	);

	apc_lane u_lane_g (
		.clk   (clk),
		.ld    (ld),
		.mode  (mode_in),
		.chan  (g_in),
		.alpha (a_in),
		.res   (g_res)
	);

	apc_lane u_lane_b (
		.clk   (clk),
		.ld    (ld),
		.mode  (mode_in),
		.chan  (b_in),
		.alpha (a_in),
		.res   (b_res)
	);

	// merge and output register
	apc_merge u_merge (
		.clk   (clk),
		.load  (ld.s4),
		.side  (side_s3),
		.red   (r_res),
		.green (g_res),
		.blue  (b_res),
		.word  (out_word),
		.last  (out_last)
	);

`ifndef SYNTHESIS
	// an empty first stage always takes an item
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with empty first stage");

	// a held first stage that cannot move on must stall the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !ld.s2) |-> in_stall)
		else $error("input accepted over an occupied stage");

	// a stalled result keeps the last lane stage holding its item
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && out_valid && out_stall) |=> v_s3)
		else $error("lane stage dropped item under output stall");

	// a loaded stage is occupied on the next cycle
	a_s3_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ld.s3 |=> v_s3)
		else $error("lane stage load lost");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/apc_lane.sv
// one colour lane: premultiply, or unpremultiply with a two-stage restoring divider
`default_nettype none
module apc_lane (
	input  wire logic                    clk,
	input  wire apc_pkg::apc_ld_t        ld,
	input  wire apc_pkg::apc_mode_t      mode,
	input  wire logic [apc_pkg::CH_W-1:0] chan,
	input  wire logic [apc_pkg::CH_W-1:0] alpha,
	output logic      [apc_pkg::CH_W-1:0] res
);

	localparam int W  = apc_pkg::CH_W;
	localparam int PW = apc_pkg::PROD_W;
	localparam int HALF = W / 2;

	// one restoring step: remainder stays below divisor
	function automatic logic [W:0] div_step(input logic [W-1:0] r, input logic b,
		input logic [W-1:0] d);
		logic [W:0] t;
		logic [W:0] o;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			o = {1'b1, W'(t - {1'b0, d})};
		end else begin
			o = {1'b0, t[W-1:0]};
		end
		return o;
	endfunction

	// stage 1
	apc_pkg::apc_mode_t mode_s1;
	logic [W-1:0]  chan_s1, alpha_s1;
	logic [PW-1:0] prod_s1, num_s1;
	logic          sat_s1;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			mode_s1  <= mode;
			chan_s1  <= chan;
			alpha_s1 <= alpha;
			prod_s1  <= {W'(0), chan} * {W'(0), alpha};
			num_s1   <= PW'({chan, W'(0)} - {W'(0), chan} + {W'(0), 1'b0, alpha[W-1:1]});
			sat_s1   <= (chan >= alpha);
		end
	end

	// stage 2: premultiply result, upper half of quotient
	logic [PW:0]    y;
	logic [PW+W:0]  z;
	logic [W-1:0]   early;
	logic [W-1:0]   rem_a;
	logic [HALF-1:0] qhi;
	logic [W:0]     st_a;

	always_comb begin
		y = {1'b0, prod_s1} + (PW+1)'(128);
		z = {y, W'(0)} + (PW+W+1)'(y);
		case (mode_s1)
			apc_pkg::MODE_MUL: begin
				if (alpha_s1 == '0) begin
					early = '0;
				end else if (alpha_s1 == apc_pkg::ALPHA_OPAQUE) begin
					early = chan_s1;
				end else begin
					early = z[PW+W-1:PW];
				end
			end
			default: early = chan_s1;
		endcase
		rem_a = num_s1[PW-1:W];
		qhi   = '0;
		for (int i = 0; i < HALF; i++) begin
			st_a  = div_step(rem_a, num_s1[W-1-i], alpha_s1);
			rem_a = st_a[W-1:0];
			qhi[HALF-1-i] = st_a[W];
		end
	end

	apc_pkg::apc_mode_t mode_s2;
	logic [W-1:0]    early_s2, alpha_s2, rem_s2;
	logic [HALF-1:0] qhi_s2, nlo_s2;
	logic            sat_s2;

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			mode_s2  <= mode_s1;
			early_s2 <= early;
			alpha_s2 <= alpha_s1;
			rem_s2   <= rem_a;
			qhi_s2   <= qhi;
			nlo_s2   <= num_s1[HALF-1:0];
			sat_s2   <= sat_s1;
		end
	end

	// stage 3: lower half of quotient and final pick
	logic [W-1:0]    rem_b;
	logic [HALF-1:0] qlo;
	logic [W:0]      st_b;
	logic [W-1:0]    fin;

	always_comb begin
		rem_b = rem_s2;
		qlo   = '0;
		for (int i = 0; i < HALF; i++) begin
			st_b  = div_step(rem_b, nlo_s2[HALF-1-i], alpha_s2);
			rem_b = st_b[W-1:0];
			qlo[HALF-1-i] = st_b[W];
		end
		case (mode_s2)
			apc_pkg::MODE_DIV: begin
				if (alpha_s2 == '0) begin
					fin = '0;
				end else if (sat_s2) begin
					fin = apc_pkg::CH_MAX;
				end else begin
					fin = {qhi_s2, qlo};
				end
			end
			default: fin = early_s2;
		endcase
	end

	logic [W-1:0] res_s3;

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			res_s3 <= fin;
		end
	end

	assign res = res_s3;

endmodule
`default_nettype wire

>>> hw/rtl/apc_merge.sv
// merge stage: packs the lane results into the output word register
`default_nettype none
module apc_merge (
	input  wire logic                    clk,
	input  wire logic                    load,
	input  wire apc_pkg::apc_side_t      side,
	input  wire logic [apc_pkg::CH_W-1:0] red,
	input  wire logic [apc_pkg::CH_W-1:0] green,
	input  wire logic [apc_pkg::CH_W-1:0] blue,
	output logic      [31:0]             word,
	output logic                         last
);

	logic [31:0] word_q;
	logic        last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (side.target) begin
				word_q <= {side.alpha, red, green, blue};
			end else begin
				word_q <= {side.alpha, blue, green, red};
			end
			last_q <= side.last;
		end
	end

	assign word = word_q;
	assign last = last_q;

endmodule
`default_nettype wire
